// ===== hw/rtl/rrfc_pkg.sv =====
// Package: types, frame constants and helpers for the read-request frame checker.
`default_nettype none

package rrfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned DEV_W    = 32;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned STATUS_W = 3;
    // status + device + count, padded to whole bytes
    localparam int unsigned RESULT_W = STATUS_W + DEV_W + CNT_W;
    localparam int unsigned M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] ENQ_BYTE = 8'h05;
    localparam logic [BYTE_W-1:0] CR_BYTE  = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_BYTE  = 8'h0A;

    // Frame positions (index of the byte being received)
    localparam logic [POS_W-1:0] POS_IDLE       = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR_LAST   = 5'd8;
    localparam logic [POS_W-1:0] POS_DEV_LAST   = 5'd12;
    localparam logic [POS_W-1:0] POS_CNT_LAST   = 5'd14;
    localparam logic [POS_W-1:0] POS_SUM_HI     = 5'd15;
    localparam logic [POS_W-1:0] POS_SUM_LO     = 5'd16;
    localparam logic [POS_W-1:0] POS_CR         = 5'd17;
    localparam logic [POS_W-1:0] POS_LF         = 5'd18;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 3'd0,
        STATUS_BAD_START   = 3'd1,
        STATUS_BAD_HEADER  = 3'd2,
        STATUS_BAD_SUM     = 3'd3,
        STATUS_BAD_TRAILER = 3'd4
    } status_t;

    // Expected header text "00FFWR0D", indexed 0..7
    function automatic logic [BYTE_W-1:0] header_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        c = "0";
        case (idx)
            3'd0: c = "0";
            3'd1: c = "0";
            3'd2: c = "F";
            3'd3: c = "F";
            3'd4: c = "W";
            3'd5: c = "R";
            3'd6: c = "0";
            3'd7: c = "D";
            default: c = "0";
        endcase
        return c;
    endfunction

    // Upper-case hex ASCII digit of a nibble
    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] n;
        n = {4'h0, nib};
        if (nib <= 4'h9)
            return n + 8'h30;
        return n - 8'h09 + 8'h40;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/read_request_frame_checker_core.sv =====
// Top level: byte-stream checker for the 19-byte ASCII word-read request frame.
//
// Usage:
//   Received bytes enter on the s_ channel, one request per byte. Frames are
//   ENQ, "00FFWR0D", four device chars, two count chars, two hex checksum
//   chars, CR, LF. One result leaves on the m_ channel when the LF-position
//   byte has been taken, and one for each non-ENQ byte seen while idle.
//   Result carries status (first error in frame order) and the raw device
//   and count characters.
// Pipeline / throughput:
//   A byte is registered on accept and checked from that input register;
//   its result is then loaded into the output register that drives m_tvalid.
//   One byte per cycle is sustained while m_tready stays high; the limit
//   is the single input register feeding the check logic.
// Reset:
//   rst_n (async, active low) empties both registers and puts the checker
//   back to waiting for ENQ with the sum cleared and all good flags set.
// Stall:
//   While m_tready is low and a result waits, the input register holds its
//   byte and s_tready drops once that register is full; no byte is lost.
`default_nettype none

module read_request_frame_checker_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input request channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rrfc_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    // result channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [rrfc_pkg::M_DATA_W-1:0]       m_tdata    // [2:0] status,
                                                           // [34:3] device_text,
                                                           // [50:35] count_text,
                                                           // [55:51] zero
);

    // input register
    logic                           in_valid_reg, in_valid_next;
    logic [rrfc_pkg::BYTE_W-1:0]    in_byte_reg, in_byte_next;

    // frame state
    logic [rrfc_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [rrfc_pkg::BYTE_W-1:0]    sum_reg, sum_next;
    logic                           hdr_good_reg, hdr_good_next;
    logic                           sum_good_reg, sum_good_next;
    logic                           trl_good_reg, trl_good_next;
    logic [rrfc_pkg::DEV_W-1:0]     dev_reg, dev_next;
    logic [rrfc_pkg::CNT_W-1:0]     cnt_reg, cnt_next;

    // result register
    logic                           out_valid_reg, out_valid_next;
    rrfc_pkg::status_t              out_status_reg, out_status_next;
    logic [rrfc_pkg::DEV_W-1:0]     out_dev_reg, out_dev_next;
    logic [rrfc_pkg::CNT_W-1:0]     out_cnt_reg, out_cnt_next;

    logic                           advance;
    logic                           emit;
    rrfc_pkg::status_t              emit_status;
    logic [rrfc_pkg::DEV_W-1:0]     emit_dev;
    logic [rrfc_pkg::CNT_W-1:0]     emit_cnt;
    logic                           lf_ok;
    logic [2:0]                     hdr_idx;

    // the held byte moves on whenever the result register is free this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // per-byte check
    always_comb
    begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        hdr_good_next = hdr_good_reg;
        sum_good_next = sum_good_reg;
        trl_good_next = trl_good_reg;
        dev_next      = dev_reg;
        cnt_next      = cnt_reg;
        emit          = 1'b0;
        emit_status   = rrfc_pkg::STATUS_OK;
        emit_dev      = '0;
        emit_cnt      = '0;
        hdr_idx       = pos_reg[2:0] - 3'd1;
        lf_ok         = (in_byte_reg == rrfc_pkg::LF_BYTE);

        if (pos_reg == rrfc_pkg::POS_IDLE)
        begin
            if (in_byte_reg != rrfc_pkg::ENQ_BYTE)
            begin
                emit        = 1'b1;
                emit_status = rrfc_pkg::STATUS_BAD_START;
            end
            else
            begin
                sum_next      = '0;
                hdr_good_next = 1'b1;
                sum_good_next = 1'b1;
                trl_good_next = 1'b1;
                dev_next      = '0;
                cnt_next      = '0;
                pos_next      = pos_reg + 5'd1;
            end
        end
        else
        begin
            if (pos_reg <= rrfc_pkg::POS_CNT_LAST)
                sum_next = sum_reg + in_byte_reg;

            if (pos_reg <= rrfc_pkg::POS_HDR_LAST)
            begin
                if (in_byte_reg != rrfc_pkg::header_char(hdr_idx))
                    hdr_good_next = 1'b0;
            end
            else if (pos_reg <= rrfc_pkg::POS_DEV_LAST)
            begin
                dev_next = {dev_reg[rrfc_pkg::DEV_W-9:0], in_byte_reg};
            end
            else if (pos_reg <= rrfc_pkg::POS_CNT_LAST)
            begin
                cnt_next = {cnt_reg[rrfc_pkg::CNT_W-9:0], in_byte_reg};
            end
            else if (pos_reg == rrfc_pkg::POS_SUM_HI)
            begin
                if (in_byte_reg != rrfc_pkg::hex_digit(sum_reg[7:4]))
                    sum_good_next = 1'b0;
            end
            else if (pos_reg == rrfc_pkg::POS_SUM_LO)
            begin
                if (in_byte_reg != rrfc_pkg::hex_digit(sum_reg[3:0]))
                    sum_good_next = 1'b0;
            end
            else if (pos_reg == rrfc_pkg::POS_CR)
            begin
                if (in_byte_reg != rrfc_pkg::CR_BYTE)
                    trl_good_next = 1'b0;
            end

            if (pos_reg >= rrfc_pkg::POS_LF)
            begin
                // LF position ends the frame whatever the byte is
                if (!lf_ok)
                    trl_good_next = 1'b0;
                emit     = 1'b1;
                emit_dev = dev_reg;
                emit_cnt = cnt_reg;
                if (!hdr_good_reg)
                    emit_status = rrfc_pkg::STATUS_BAD_HEADER;
                else if (!sum_good_reg)
                    emit_status = rrfc_pkg::STATUS_BAD_SUM;
                else if (!trl_good_reg || !lf_ok)
                    emit_status = rrfc_pkg::STATUS_BAD_TRAILER;
                else
                    emit_status = rrfc_pkg::STATUS_OK;
                pos_next = rrfc_pkg::POS_IDLE;
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_dev_next    = out_dev_reg;
        out_cnt_next    = out_cnt_reg;
        if (advance && emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = emit_status;
            out_dev_next    = emit_dev;
            out_cnt_next    = emit_cnt;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= rrfc_pkg::POS_IDLE;
            sum_reg       <= '0;
            hdr_good_reg  <= 1'b1;
            sum_good_reg  <= 1'b1;
            trl_good_reg  <= 1'b1;
            dev_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                pos_reg      <= pos_next;
                sum_reg      <= sum_next;
                hdr_good_reg <= hdr_good_next;
                sum_good_reg <= sum_good_next;
                trl_good_reg <= trl_good_next;
                dev_reg      <= dev_next;
                cnt_reg      <= cnt_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        in_byte_reg    <= in_byte_next;
        out_status_reg <= out_status_next;
        out_dev_reg    <= out_dev_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rrfc_pkg::M_DATA_W - rrfc_pkg::RESULT_W){1'b0}},
                       out_cnt_reg, out_dev_reg, out_status_reg};

endmodule

`default_nettype wire
